@@ hw/rtl/mlp_pkg.sv @@
package mlp_pkg;

   localparam int MAX_NODES = 4;
   localparam int SIG_DEPTH = 256;
   localparam int LANE_IDX_W = 2;
   localparam int SIG_STEP = 1048576 / SIG_DEPTH;

   typedef logic [16:0] sig_table_type [SIG_DEPTH];

   // multiplier operand pairs of a lane
   typedef enum logic [3:0] {
      MS_NONE,
      MS_A_W1,
      MS_H_W2,
      MS_DSIG,
      MS_B_W2,
      MS_P_T,
      MS_LR_H,
      MS_T_B,
      MS_LR_B,
      MS_T_D,
      MS_LR_D
   } mul_sel_type;

   // where a lane puts the previous product, its bias, a sigmoid or a written value
   typedef enum logic [3:0] {
      DS_NONE,
      DS_ACC_BIAS,
      DS_ACC_ADD,
      DS_SIG,
      DS_TMP,
      DS_D,
      DS_W2_SUB,
      DS_W1_SUB,
      DS_B1_SUB,
      DS_WR_W1,
      DS_WR_B1,
      DS_WR_W2
   } dst_sel_type;

   typedef struct packed {
      mul_sel_type              mul;
      dst_sel_type              dst;
      logic [LANE_IDX_W-1:0]    k;
      logic signed [23:0]       bcast;
   } lane_ctl_type;

   typedef enum logic [3:0] {
      MOP_NONE,
      MOP_LOAD,
      MOP_ADD,
      MOP_SIG,
      MOP_ERR,
      MOP_DO,
      MOP_LRD,
      MOP_B2SUB,
      MOP_WR_B2
   } merge_op_type;

   localparam logic [1:0] CSR_LR  = 2'd0;
   localparam logic [1:0] CSR_THR = 2'd1;
   localparam logic [1:0] CSR_NI  = 2'd2;
   localparam logic [1:0] CSR_NH  = 2'd3;

   localparam logic [1:0] KIND_WRITE  = 2'd0;
   localparam logic [1:0] KIND_TRAIN  = 2'd1;
   localparam logic [1:0] KIND_FWD    = 2'd2;
   localparam logic [1:0] KIND_UNUSED = 2'd3;

   localparam logic [2:0] SRC_BIAS = 3'd4;

   function automatic logic signed [23:0] sat24(input logic signed [33:0] v);
      logic signed [23:0] r;
      if (v > 34'sd8388607) r = 24'sh7FFFFF;
      else if (v < -34'sd8388608) r = 24'sh800000;
      else r = v[23:0];
      return r;
   endfunction

   // Q8.16 product, floored, saturated
   function automatic logic signed [23:0] fmul(input logic signed [24:0] a,
                                               input logic signed [24:0] b);
      logic signed [49:0] p;
      logic signed [33:0] q;
      p = a * b;
      q = 34'(p >>> 16);
      return sat24(q);
   endfunction

   function automatic logic signed [23:0] add_sat(input logic signed [23:0] a,
                                                  input logic signed [23:0] b);
      return sat24(34'(a) + 34'(b));
   endfunction

   function automatic logic signed [23:0] sub_sat(input logic signed [23:0] a,
                                                  input logic signed [23:0] b);
      return sat24(34'(a) - 34'(b));
   endfunction

   // shift-subtract quotient, used only while building the table
   function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
      logic [63:0] q, r;
      q = '0;
      r = '0;
      for (int i = 63; i >= 0; i--) begin
         r = {r[62:0], n[i]};
         if (r >= d) begin
            r = r - d;
            q[i] = 1'b1;
         end
      end
      return q;
   endfunction

   // elaboration-time build of the sigmoid table: e^|x| by Taylor series in Q32
   function automatic sig_table_type build_sig_table();
      sig_table_type t;
      logic signed [63:0] x;
      logic [63:0] u, term, e, den, s, one;
      for (int i = 0; i < SIG_DEPTH; i++) begin
         x = 64'(i) * 64'(SIG_STEP) - 64'sd524288;
         u = (x < 0) ? 64'(-x) : 64'(x);
         one = 64'd1 << 32;
         term = one;
         e = one;
         for (int n = 1; n < 100; n++) begin
            if (term != 64'd0) begin
               term = udiv64((term * u) >> 16, 64'(n));
               e = e + term;
            end
         end
         den = e + one;
         if (x >= 0) s = udiv64(64'd65536 * e + (den >> 1), den);
         else s = udiv64((64'd1 << 48) + (den >> 1), den);
         t[i] = s[16:0];
      end
      return t;
   endfunction

   localparam sig_table_type SIG_TABLE = build_sig_table();

   function automatic logic [16:0] sigmoid(input logic signed [23:0] x);
      logic signed [24:0] t;
      logic [7:0] idx;
      t = 25'(x) + 25'sd524288;
      if (t < 0) idx = 8'd0;
      else if (t[24:12] > 13'd255) idx = 8'd255;
      else idx = t[19:12];
      return SIG_TABLE[idx];
   endfunction

endpackage

@@ hw/rtl/mlp_lane.sv @@
module mlp_lane (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  mlp_pkg::lane_ctl_type ctl,
   input  logic [18:0]          lr,
   output logic signed [23:0]   prod
);
   import mlp_pkg::*;

   logic signed [23:0] w1_ff [MAX_NODES];
   logic signed [23:0] w1_in [MAX_NODES];
   logic signed [23:0] b1_ff, b1_in, w2_ff, w2_in;
   logic signed [23:0] acc_ff, acc_in, tmp_ff, tmp_in, d_ff, d_in, prod_ff, prod_in;
   logic [16:0] h_ff, h_in;
   logic signed [24:0] ma, mb, h_x, lr_x;

   assign h_x  = $signed({8'b0, h_ff});
   assign lr_x = $signed({6'b0, lr});

   always_comb begin
      ma = '0;
      mb = '0;
      unique case (ctl.mul)
         MS_NONE: begin ma = '0; mb = '0; end
         MS_A_W1: begin ma = 25'(ctl.bcast); mb = 25'(w1_ff[ctl.k]); end
         MS_H_W2: begin ma = h_x; mb = 25'(w2_ff); end
         MS_DSIG: begin ma = h_x; mb = 25'sd65536 - h_x; end
         MS_B_W2: begin ma = 25'(ctl.bcast); mb = 25'(w2_ff); end
         MS_P_T:  begin ma = 25'(prod_ff); mb = 25'(tmp_ff); end
         MS_LR_H: begin ma = lr_x; mb = h_x; end
         MS_T_B:  begin ma = 25'(tmp_ff); mb = 25'(ctl.bcast); end
         MS_LR_B: begin ma = lr_x; mb = 25'(ctl.bcast); end
         MS_T_D:  begin ma = 25'(tmp_ff); mb = 25'(d_ff); end
         MS_LR_D: begin ma = lr_x; mb = 25'(d_ff); end
         default: begin ma = '0; mb = '0; end
      endcase
   end

   always_comb begin
      w1_in   = w1_ff;
      b1_in   = b1_ff;
      w2_in   = w2_ff;
      acc_in  = acc_ff;
      tmp_in  = tmp_ff;
      d_in    = d_ff;
      h_in    = h_ff;
      prod_in = prod_ff;
      if (en) begin
         if (ctl.mul != MS_NONE) prod_in = fmul(ma, mb);
         unique case (ctl.dst)
            DS_NONE:     ;
            DS_ACC_BIAS: acc_in = b1_ff;
            DS_ACC_ADD:  acc_in = add_sat(acc_ff, prod_ff);
            DS_SIG:      h_in = sigmoid(acc_ff);
            DS_TMP:      tmp_in = prod_ff;
            DS_D:        d_in = prod_ff;
            DS_W2_SUB:   w2_in = sub_sat(w2_ff, prod_ff);
            DS_W1_SUB:   w1_in[ctl.k] = sub_sat(w1_ff[ctl.k], prod_ff);
            DS_B1_SUB:   b1_in = sub_sat(b1_ff, prod_ff);
            DS_WR_W1:    w1_in[ctl.k] = ctl.bcast;
            DS_WR_B1:    b1_in = ctl.bcast;
            DS_WR_W2:    w2_in = ctl.bcast;
            default:     ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_NODES; i++) w1_ff[i] <= '0;
         b1_ff <= '0;
         w2_ff <= '0;
      end else begin
         w1_ff <= w1_in;
         b1_ff <= b1_in;
         w2_ff <= w2_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff  <= acc_in;
      tmp_ff  <= tmp_in;
      d_ff    <= d_in;
      h_ff    <= h_in;
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

@@ hw/rtl/mlp_merge.sv @@
module mlp_merge (
   input  logic                  clock,
   input  logic                  reset,
   input  mlp_pkg::merge_op_type mop,
   input  logic [1:0]            k,
   input  logic signed [23:0]    lane_prod [mlp_pkg::MAX_NODES],
   input  logic [18:0]           lr,
   input  logic [16:0]           target,
   input  logic signed [23:0]    wval,
   output logic signed [23:0]    d_out,
   output logic [16:0]           o_out,
   output logic [16:0]           hse_out
);
   import mlp_pkg::*;

   logic signed [23:0] b2_ff, b2_in, acc_ff, acc_in, p_ff, p_in, d_ff, d_in;
   logic [16:0] o_ff, o_in, hse_ff, hse_in;
   logic signed [24:0] o_x;
   logic signed [17:0] diff;
   logic signed [35:0] sq;
   logic [18:0] hse_raw;

   assign o_x = $signed({8'b0, o_ff});
   assign diff = $signed({1'b0, target}) - $signed({1'b0, o_ff});
   assign sq = diff * diff;
   assign hse_raw = 19'(sq >>> 17);

   always_comb begin
      b2_in  = b2_ff;
      acc_in = acc_ff;
      p_in   = p_ff;
      d_in   = d_ff;
      o_in   = o_ff;
      hse_in = hse_ff;
      unique case (mop)
         MOP_NONE:  ;
         MOP_LOAD:  acc_in = b2_ff;
         MOP_ADD:   acc_in = add_sat(acc_ff, lane_prod[k]);
         MOP_SIG:   o_in = sigmoid(acc_ff);
         MOP_ERR: begin
            hse_in = (hse_raw > 19'd131071) ? 17'h1FFFF : hse_raw[16:0];
            p_in = fmul(o_x, 25'sd65536 - o_x);
         end
         MOP_DO:    d_in = fmul(o_x - $signed({8'b0, target}), 25'(p_ff));
         MOP_LRD:   p_in = fmul($signed({6'b0, lr}), 25'(d_ff));
         MOP_B2SUB: b2_in = sub_sat(b2_ff, p_ff);
         MOP_WR_B2: b2_in = wval;
         default:   ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) b2_ff <= '0;
      else b2_ff <= b2_in;
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      p_ff   <= p_in;
      d_ff   <= d_in;
      o_ff   <= o_in;
      hse_ff <= hse_in;
   end

   assign d_out   = d_ff;
   assign o_out   = o_ff;
   assign hse_out = hse_ff;

endmodule

@@ hw/rtl/mlp_backprop_train_step.sv @@
// Sigmoid perceptron (inputs, up to four hidden nodes, one output) that trains
// by backpropagation in Q8.16 fixed point.
// req_ channel: one item per handshake (valid high, stall low). kind 0 writes
// a weight or bias and gives no result; kind 1 trains on a sample; kind 2 runs
// forward only; kind 3 is dropped. Kinds 1 and 2 give one rsp_ item with the
// output activation, half squared error and below-threshold flag.
// csr_ channel: valid/ready write of register index and data; ready is always
// high, writes are meant to happen only while the block is idle.
// One item is worked at a time; req_stall is high until it is finished.
// The NI input and NH hidden-node counts in use are each capped at four.
// The per-lane multiplier walks the inputs one per step; four hidden lanes run
// side by side and the output node adds their products one per cycle.
// A finished result sits in the output register while rsp_stall is high; the
// next item is taken meanwhile but can not finish until that slot frees.
// Reset clears weights, biases and the handshake and sets the csr_ registers to their defaults.
module mlp_backprop_train_step (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_kind,
   input  logic signed [23:0] req_in_0,
   input  logic signed [23:0] req_in_1,
   input  logic signed [23:0] req_in_2,
   input  logic signed [23:0] req_in_3,
   input  logic [16:0]        req_target,
   input  logic               req_layer_sel,
   input  logic [1:0]         req_node_sel,
   input  logic [2:0]         req_src_sel,
   input  logic signed [23:0] req_weight_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [16:0]        rsp_out_activation,
   output logic [16:0]        rsp_half_sq_error,
   output logic               rsp_below_threshold,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [18:0]        csr_data
);
   import mlp_pkg::*;

   typedef enum logic [18:0] {
      S_IDLE  = 19'b1 << 0,
      S_WRITE = 19'b1 << 1,
      S_FBIAS = 19'b1 << 2,
      S_FMUL  = 19'b1 << 3,
      S_FACC  = 19'b1 << 4,
      S_FSIG  = 19'b1 << 5,
      S_OMUL  = 19'b1 << 6,
      S_OACC  = 19'b1 << 7,
      S_OSIG  = 19'b1 << 8,
      S_ERR   = 19'b1 << 9,
      S_DO    = 19'b1 << 10,
      S_BACK  = 19'b1 << 11,
      S_DELTA = 19'b1 << 12,
      S_DSET  = 19'b1 << 13,
      S_W2A   = 19'b1 << 14,
      S_W2B   = 19'b1 << 15,
      S_W2C   = 19'b1 << 16,
      S_B1    = 19'b1 << 17,
      S_DONE  = 19'b1 << 18
   } state_type;

   // sub-step of the layer-one weight walk
   logic [1:0] wstep_ff, wstep_in;

   state_type state_ff, state_in;
   logic [2:0] k_ff, k_in;
   logic [1:0] kind_ff;
   logic signed [23:0] a_ff [MAX_NODES];
   logic [16:0] target_ff;
   logic layer_ff;
   logic [1:0] node_ff;
   logic [2:0] src_ff;
   logic signed [23:0] wval_ff;

   logic [18:0] lr_ff;
   logic [16:0] thr_ff;
   logic [2:0] ni_ff, nh_ff, ni_eff, nh_eff;

   logic rsp_valid_ff;
   logic [16:0] rsp_act_ff, rsp_hse_ff;
   logic rsp_below_ff;

   lane_ctl_type ctl;
   merge_op_type mop;
   logic [MAX_NODES-1:0] lane_en;
   logic signed [23:0] lane_prod [MAX_NODES];
   logic signed [23:0] d_o;
   logic [16:0] o_val, hse_val;
   logic accept, k_last_i, k_last_h, out_free;

   assign ni_eff = (ni_ff > 3'(MAX_NODES)) ? 3'(MAX_NODES) : ni_ff;
   assign nh_eff = (nh_ff > 3'(MAX_NODES)) ? 3'(MAX_NODES) : nh_ff;
   assign accept = req_valid && !req_stall;
   assign k_last_i = (3'(k_ff + 3'd1) == ni_eff);
   assign k_last_h = (3'(k_ff + 3'd1) == nh_eff);
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;

   always_comb begin
      state_in = state_ff;
      k_in = k_ff;
      wstep_in = wstep_ff;
      ctl.mul = MS_NONE;
      ctl.dst = DS_NONE;
      ctl.k = k_ff[1:0];
      ctl.bcast = a_ff[k_ff[1:0]];
      mop = MOP_NONE;
      for (int j = 0; j < MAX_NODES; j++) lane_en[j] = (3'(j) < nh_eff);
      unique case (state_ff)
         S_IDLE: begin
            k_in = '0;
            wstep_in = '0;
            if (accept) begin
               if (req_kind == KIND_WRITE) state_in = S_WRITE;
               else if (req_kind == KIND_TRAIN || req_kind == KIND_FWD) state_in = S_FBIAS;
            end
         end
         S_WRITE: begin
            lane_en = '0;
            ctl.bcast = wval_ff;
            ctl.k = src_ff[1:0];
            if (!layer_ff) begin
               lane_en[node_ff] = 1'b1;
               if (src_ff == SRC_BIAS) ctl.dst = DS_WR_B1;
               else if (src_ff < SRC_BIAS) ctl.dst = DS_WR_W1;
            end else if (node_ff == 2'd0) begin
               if (src_ff == SRC_BIAS) mop = MOP_WR_B2;
               else if (src_ff < SRC_BIAS) begin
                  lane_en[src_ff[1:0]] = 1'b1;
                  ctl.dst = DS_WR_W2;
               end
            end
            state_in = S_IDLE;
         end
         S_FBIAS: begin
            ctl.dst = DS_ACC_BIAS;
            k_in = '0;
            state_in = (ni_eff == 3'd0) ? S_FSIG : S_FMUL;
         end
         S_FMUL: begin
            ctl.mul = MS_A_W1;
            state_in = S_FACC;
         end
         S_FACC: begin
            ctl.dst = DS_ACC_ADD;
            k_in = 3'(k_ff + 3'd1);
            state_in = k_last_i ? S_FSIG : S_FMUL;
         end
         S_FSIG: begin
            ctl.dst = DS_SIG;
            state_in = S_OMUL;
         end
         S_OMUL: begin
            ctl.mul = MS_H_W2;
            mop = MOP_LOAD;
            k_in = '0;
            state_in = (nh_eff == 3'd0) ? S_OSIG : S_OACC;
         end
         S_OACC: begin
            mop = MOP_ADD;
            k_in = 3'(k_ff + 3'd1);
            if (k_last_h) state_in = S_OSIG;
         end
         S_OSIG: begin
            mop = MOP_SIG;
            state_in = S_ERR;
         end
         S_ERR: begin
            mop = MOP_ERR;
            ctl.mul = MS_DSIG;
            state_in = (kind_ff == KIND_TRAIN) ? S_DO : S_DONE;
         end
         S_DO: begin
            mop = MOP_DO;
            ctl.dst = DS_TMP;
            state_in = S_BACK;
         end
         S_BACK: begin
            ctl.mul = MS_B_W2;
            ctl.bcast = d_o;
            state_in = S_DELTA;
         end
         S_DELTA: begin
            ctl.mul = MS_P_T;
            state_in = S_DSET;
         end
         S_DSET: begin
            ctl.dst = DS_D;
            ctl.mul = MS_LR_H;
            mop = MOP_LRD;
            state_in = S_W2A;
         end
         S_W2A: begin
            ctl.dst = DS_TMP;
            mop = MOP_B2SUB;
            state_in = S_W2B;
         end
         S_W2B: begin
            ctl.mul = MS_T_B;
            ctl.bcast = d_o;
            state_in = S_W2C;
         end
         S_W2C: begin
            ctl.dst = DS_W2_SUB;
            ctl.mul = MS_LR_D;
            k_in = '0;
            state_in = S_B1;
         end
         S_B1: begin
            // bias update while lr*a of input 0 forms; then per input TMP,
            // T_D and W1_SUB, the last overlapping lr*a of the next input
            if (wstep_ff == 2'd0) begin
               ctl.dst = DS_B1_SUB;
               ctl.mul = MS_LR_B;
               wstep_in = 2'd2;
               if (ni_eff == 3'd0) state_in = S_DONE;
            end else begin
               unique case (wstep_ff)
                  2'd2: begin
                     ctl.dst = DS_TMP;
                     wstep_in = 2'd3;
                  end
                  2'd3: begin
                     ctl.mul = MS_T_D;
                     wstep_in = 2'd1;
                  end
                  2'd1: begin
                     ctl.dst = DS_W1_SUB;
                     ctl.mul = MS_LR_B;
                     ctl.bcast = a_ff[2'(k_ff[1:0] + 2'd1)];
                     wstep_in = 2'd2;
                     k_in = 3'(k_ff + 3'd1);
                     if (k_last_i) state_in = S_DONE;
                  end
                  default: ;
               endcase
            end
         end
         S_DONE: begin
            if (out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         k_ff <= '0;
         wstep_ff <= '0;
         rsp_valid_ff <= 1'b0;
         lr_ff <= 19'd32768;
         thr_ff <= 17'd655;
         ni_ff <= 3'd2;
         nh_ff <= 3'd2;
      end else begin
         state_ff <= state_in;
         k_ff <= k_in;
         wstep_ff <= wstep_in;
         if (state_ff == S_DONE && out_free) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_LR:  lr_ff <= csr_data;
               CSR_THR: thr_ff <= csr_data[16:0];
               CSR_NI:  ni_ff <= csr_data[2:0];
               CSR_NH:  nh_ff <= csr_data[2:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff <= req_kind;
         a_ff[0] <= req_in_0;
         a_ff[1] <= req_in_1;
         a_ff[2] <= req_in_2;
         a_ff[3] <= req_in_3;
         target_ff <= req_target;
         layer_ff <= req_layer_sel;
         node_ff <= req_node_sel;
         src_ff <= req_src_sel;
         wval_ff <= req_weight_value;
      end
      if (state_ff == S_DONE && out_free) begin
         rsp_act_ff <= o_val;
         rsp_hse_ff <= hse_val;
         rsp_below_ff <= (hse_val < thr_ff);
      end
   end

   for (genvar j = 0; j < MAX_NODES; j++) begin : g_lane
      mlp_lane u_lane (
         .clock (clock),
         .reset (reset),
         .en    (lane_en[j]),
         .ctl   (ctl),
         .lr    (lr_ff),
         .prod  (lane_prod[j])
      );
   end

   mlp_merge u_merge (
      .clock     (clock),
      .reset     (reset),
      .mop       (mop),
      .k         (k_ff[1:0]),
      .lane_prod (lane_prod),
      .lr        (lr_ff),
      .target    (target_ff),
      .wval      (wval_ff),
      .d_out     (d_o),
      .o_out     (o_val),
      .hse_out   (hse_val)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_out_activation = rsp_act_ff;
   assign rsp_half_sq_error = rsp_hse_ff;
   assign rsp_below_threshold = rsp_below_ff;

endmodule

@@ hw/rtl/mlp_checker.sv @@
module mlp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic [1:0]  req_kind,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [16:0] rsp_out_activation,
   input logic [16:0] rsp_half_sq_error
);
   import mlp_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   a_act_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_out_activation <= 17'd65536)
      else $error("activation above one");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_out_activation) && $stable(rsp_half_sq_error))
      else $error("result changed while stalled");

   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_kind == KIND_WRITE || req_kind == KIND_TRAIN
         || req_kind == KIND_FWD) |=> req_stall)
      else $error("item accepted without going busy");

endmodule

bind mlp_backprop_train_step mlp_checker u_mlp_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_stall          (req_stall),
   .req_kind           (req_kind),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_out_activation (rsp_out_activation),
   .rsp_half_sq_error  (rsp_half_sq_error)
);

@@ tb/sv/tb_mlp_backprop_train_step.sv @@
`timescale 1ns / 1ps

module tb_mlp_backprop_train_step;
   import mlp_pkg::*;

   typedef struct {
      logic [1:0]         kind;
      logic signed [23:0] feat [4];
      logic [16:0]        target;
      logic               layer_sel;
      logic [1:0]         node_sel;
      logic [2:0]         src_sel;
      logic signed [23:0] wval;
   } sample_type;

   typedef struct {
      logic [16:0] act;
      logic [16:0] hse;
      logic        below;
   } score_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [1:0]         req_kind = '0;
   logic signed [23:0] req_in_0 = '0, req_in_1 = '0, req_in_2 = '0, req_in_3 = '0;
   logic [16:0]        req_target = '0;
   logic               req_layer_sel = 1'b0;
   logic [1:0]         req_node_sel = '0;
   logic [2:0]         req_src_sel = '0;
   logic signed [23:0] req_weight_value = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [16:0]        rsp_out_activation, rsp_half_sq_error;
   logic               rsp_below_threshold;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [1:0]         csr_index = '0;
   logic [18:0]        csr_data = '0;

   mlp_backprop_train_step uut (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // predictor state
   longint      lut [256];
   longint      wt [32];
   longint      bs [8];
   longint      act [12];
   longint      dl [12];
   logic [18:0] lrate;
   logic [16:0] thresh;
   logic [2:0]  n_in, n_hid;

   sample_type pending [$];
   score_type  scores_due [$];
   sample_type cur;
   int unsigned cyc = 0;
   int errors = 0, n_results = 0, n_trains = 0, n_fwds = 0, n_writes = 0;

   task automatic queue_item(sample_type s);
      pending = {pending, s};
   endtask

   function automatic longint clip24(longint v);
      if (v > 8388607) return 8388607;
      if (v < -8388608) return -8388608;
      return v;
   endfunction

   function automatic longint qmul(longint a, longint b);
      longint p;
      p = a * b;
      return clip24(p >>> 16);
   endfunction

   function automatic longint lookup_sig(longint x);
      longint t;
      if (x < -524288) return lut[0];
      t = (x + 524288) >>> 12;
      if (t > 255) t = 255;
      return lut[t];
   endfunction

   function automatic int nodes_in(int l);
      int c;
      if (l == 2) return 1;
      c = (l == 0) ? n_in : n_hid;
      return (c > 4) ? 4 : c;
   endfunction

   task automatic build_lut();
      longint x;
      bit [63:0] u, term, e, den, one;
      for (int i = 0; i < 256; i++) begin
         x = longint'(i) * 4096 - 524288;
         u = (x < 0) ? -x : x;
         one = 64'd1 << 32;
         term = one;
         e = one;
         for (int n = 1; n < 100 && term != 0; n++) begin
            term = ((term * u) >> 16) / n;
            e = e + term;
         end
         den = e + one;
         if (x >= 0) lut[i] = longint'((64'd65536 * e + den / 2) / den);
         else lut[i] = longint'(((64'd1 << 48) + den / 2) / den);
      end
   endtask

   task automatic apply_sample(sample_type s);
      longint acc, o, diff, hse, d, stp;
      int nj, nk, wi;
      score_type r;
      if (s.kind == KIND_WRITE) begin
         n_writes++;
         if (s.src_sel == SRC_BIAS) bs[s.layer_sel * 4 + s.node_sel] = s.wval;
         else if (s.src_sel < 4)
            wt[(s.layer_sel * 4 + s.node_sel) * 4 + s.src_sel] = s.wval;
         return;
      end
      if (s.kind != KIND_TRAIN && s.kind != KIND_FWD) return;
      for (int j = 0; j < 4; j++) act[j] = s.feat[j];
      for (int l = 1; l < 3; l++) begin
         nj = nodes_in(l);
         nk = nodes_in(l - 1);
         for (int j = 0; j < nj; j++) begin
            acc = bs[(l - 1) * 4 + j];
            for (int k = 0; k < nk; k++)
               acc = clip24(acc + qmul(act[(l - 1) * 4 + k], wt[((l - 1) * 4 + j) * 4 + k]));
            act[l * 4 + j] = lookup_sig(acc);
         end
      end
      o = act[8];
      diff = longint'(s.target) - o;
      hse = (diff * diff) >>> 17;
      if (hse > 131071) hse = 131071;
      if (s.kind == KIND_TRAIN) begin
         n_trains++;
         dl[8] = qmul(o - longint'(s.target), qmul(o, 65536 - o));
         nj = nodes_in(1);
         for (int j = 0; j < nj; j++) begin
            acc = clip24(qmul(dl[8], wt[16 + j]));
            dl[4 + j] = qmul(acc, qmul(act[4 + j], 65536 - act[4 + j]));
         end
         for (int l = 1; l < 3; l++) begin
            nj = nodes_in(l);
            nk = nodes_in(l - 1);
            for (int j = 0; j < nj; j++) begin
               d = dl[l * 4 + j];
               for (int k = 0; k < nk; k++) begin
                  stp = qmul(qmul(longint'(lrate), act[(l - 1) * 4 + k]), d);
                  wi = ((l - 1) * 4 + j) * 4 + k;
                  wt[wi] = clip24(wt[wi] - stp);
               end
               bs[(l - 1) * 4 + j] = clip24(bs[(l - 1) * 4 + j] - qmul(longint'(lrate), d));
            end
         end
      end else begin
         n_fwds++;
      end
      r.act = o[16:0];
      r.hse = hse[16:0];
      r.below = (hse < longint'(thresh));
      scores_due = {scores_due, r};
   endtask

   function automatic bit take_break();
      if (cyc > 2500 && cyc < 7000) return 1'b0;
      return $urandom_range(0, 99) < 9;
   endfunction

   // request driver
   always @(posedge clock) begin
      sample_type nxt;
      cyc <= cyc + 1;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) apply_sample(cur);
         if (!req_valid || !req_stall) begin
            if (pending.size() > 0 && !take_break()) begin
               nxt = pending.pop_front();
               cur = nxt;
               req_kind <= nxt.kind;
               req_in_0 <= nxt.feat[0];
               req_in_1 <= nxt.feat[1];
               req_in_2 <= nxt.feat[2];
               req_in_3 <= nxt.feat[3];
               req_target <= nxt.target;
               req_layer_sel <= nxt.layer_sel;
               req_node_sel <= nxt.node_sel;
               req_src_sel <= nxt.src_sel;
               req_weight_value <= nxt.wval;
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      score_type want;
      rsp_stall <= reset ? 1'b0 : take_break();
      if (!reset && rsp_valid && !rsp_stall) begin
         n_results++;
         if (scores_due.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result act=%0d hse=%0d",
                                       rsp_out_activation, rsp_half_sq_error);
         end else begin
            want = scores_due.pop_front();
            if (rsp_out_activation !== want.act || rsp_half_sq_error !== want.hse ||
                rsp_below_threshold !== want.below) begin
               errors++;
               if (errors <= 10)
                  $display("mismatch: act %0d/%0d hse %0d/%0d below %0b/%0b (exp/got)",
                           want.act, rsp_out_activation, want.hse, rsp_half_sq_error,
                           want.below, rsp_below_threshold);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (cyc > 3000000) begin
         $display("timeout");
         $display("FAIL mlp_backprop_train_step");
         $finish;
      end
   end

   function automatic logic signed [23:0] rand_q();
      case ($urandom_range(0, 3))
         0: return 24'($urandom);
         default: return $signed(24'($urandom_range(0, 393216))) - 24'sd196608;
      endcase
   endfunction

   function automatic sample_type mk(logic [1:0] kind);
      sample_type s;
      s.kind = kind;
      for (int i = 0; i < 4; i++) s.feat[i] = rand_q();
      s.target = ($urandom_range(0, 9) == 0) ? 17'($urandom) : 17'($urandom_range(0, 65536));
      s.layer_sel = 1'($urandom);
      s.node_sel = 2'($urandom);
      s.src_sel = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7))
                                             : 3'($urandom_range(0, 4));
      s.wval = rand_q();
      return s;
   endfunction

   task automatic put_weight(logic ls, logic [1:0] node, logic [2:0] src,
                             logic signed [23:0] v);
      sample_type s;
      s = mk(KIND_WRITE);
      s.layer_sel = ls;
      s.node_sel = node;
      s.src_sel = src;
      s.wval = v;
      queue_item(s);
   endtask

   task automatic csr_write(logic [1:0] idx, logic [18:0] v);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_LR:  lrate = v;
         CSR_THR: thresh = v[16:0];
         CSR_NI:  n_in = v[2:0];
         CSR_NH:  n_hid = v[2:0];
         default: ;
      endcase
   endtask

   task automatic drain();
      do @(negedge clock); while (pending.size() > 0 || req_valid || scores_due.size() > 0);
      repeat (80) @(negedge clock);
   endtask

   task automatic random_phase(int count);
      int p;
      for (int i = 0; i < count; i++) begin
         p = $urandom_range(0, 99);
         if (p < 30) queue_item(mk(KIND_WRITE));
         else if (p < 70) queue_item(mk(KIND_TRAIN));
         else if (p < 95) queue_item(mk(KIND_FWD));
         else queue_item(mk(KIND_UNUSED));
      end
   endtask

   initial begin
      sample_type s;
      logic [18:0] cfg [6][4];
      build_lut();
      foreach (wt[i]) wt[i] = 0;
      foreach (bs[i]) bs[i] = 0;
      foreach (act[i]) act[i] = 0;
      foreach (dl[i]) dl[i] = 0;
      lrate = 32768;
      thresh = 655;
      n_in = 2;
      n_hid = 2;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: load every weight and bias, bad addresses, extremes
      for (int l = 0; l < 2; l++)
         for (int j = 0; j < 4; j++)
            for (int k = 0; k < 8; k++)
               if (k < 5 || (l == 0 && j == 0))
                  put_weight(1'(l), 2'(j), 3'(k), rand_q());
      s = mk(KIND_TRAIN);
      foreach (s.feat[i]) s.feat[i] = 24'sh7FFFFF;
      s.target = 17'h1FFFF;
      queue_item(s);
      s = mk(KIND_FWD);
      foreach (s.feat[i]) s.feat[i] = 24'sh800000;
      s.target = '0;
      queue_item(s);
      s = mk(KIND_TRAIN);
      foreach (s.feat[i]) s.feat[i] = 0;
      s.target = 17'd65536;
      queue_item(s);
      queue_item(mk(KIND_UNUSED));
      put_weight(1'b1, 2'd0, 3'd0, 24'sh7FFFFF);
      put_weight(1'b1, 2'd0, SRC_BIAS, 24'sh800000);
      queue_item(mk(KIND_FWD));
      queue_item(mk(KIND_TRAIN));
      drain();

      cfg[0] = '{19'd0, 19'd0, 19'd0, 19'd0};
      cfg[1] = '{19'h7FFFF, 19'h7FFFF, 19'd7, 19'd7};
      cfg[2] = '{19'd4096, 19'd65536, 19'd4, 19'd4};
      cfg[3] = '{19'd1, 19'd1, 19'd1, 19'd1};
      cfg[4] = '{19'd65536, 19'd2000, 19'd3, 19'd2};
      cfg[5] = '{19'd262144, 19'd655, 19'd4, 19'd3};
      for (int ph = 0; ph < 6; ph++) begin
         for (int r = 0; r < 4; r++) csr_write(r[1:0], cfg[ph][r]);
         random_phase(72);
         drain();
      end
      csr_write(CSR_LR, 19'($urandom_range(0, 262144)));
      csr_write(CSR_THR, 19'($urandom_range(0, 65536)));
      csr_write(CSR_NI, 19'($urandom_range(1, 4)));
      csr_write(CSR_NH, 19'($urandom_range(1, 4)));
      random_phase(70);
      drain();

      $display("covered %0d trains, %0d forward passes, %0d weight writes",
               n_trains, n_fwds, n_writes);
      $display("%0d results checked over eight register settings", n_results);
      if (errors == 0 && scores_due.size() == 0) begin
         $display("PASS mlp_backprop_train_step");
      end else begin
         $display("%0d mismatches", errors);
         $display("FAIL mlp_backprop_train_step");
      end
      $finish;
   end

endmodule

@@ sim.f @@
hw/rtl/mlp_pkg.sv
hw/rtl/mlp_lane.sv
hw/rtl/mlp_merge.sv
hw/rtl/mlp_backprop_train_step.sv
hw/rtl/mlp_checker.sv
tb/sv/tb_mlp_backprop_train_step.sv
